// ----- src/bbg_pkg.sv -----
// shared constants, register codes and types for the bayer to gray block
`default_nettype none

package bbg_pkg;

   localparam int PIX_W         = 8;
   localparam int CSR_W         = 11;
   localparam int CSR_IDX_W     = 1;
   localparam int ROW_W         = 10;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_MAX    = 1024;
   localparam int DIM_MIN       = 3;

   localparam logic [CSR_W-1:0] LINE_WIDTH_RST   = CSR_W'(320);
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RST = CSR_W'(200);

   // luma weights in 0.8 fixed point (they sum to 256)
   localparam logic [7:0] W_RED   = 8'd77;
   localparam logic [7:0] W_GREEN = 8'd150;
   localparam logic [7:0] W_BLUE  = 8'd29;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LINE_WIDTH   = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // per-pixel control carried alongside the sample
   typedef struct packed {
      logic interior;
      logic x_odd;
      logic y_odd;
      logic last;
   } pix_flags_type;

   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
      logic             last;
   } rgb_type;

endpackage

`default_nettype wire

// ----- src/bbg_line_store.sv -----
// single line store: one write port, one registered read port
`default_nettype none

module bbg_line_store
   import bbg_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [PIX_W-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents when the same entry is written in the cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/bbg_window.sv -----
// line store access, 3x3 window and bilinear colour rebuild
`default_nettype none

module bbg_window
   import bbg_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int CW        = $clog2(MAX_WIDTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_accept,
   input  wire logic [PIX_W-1:0] in_raw,
   input  wire logic [CW-1:0]    in_col,
   input  wire pix_flags_type    in_flags,
   output logic                  in_ready,
   output logic                  rgb_valid,
   output rgb_type               rgb_data,
   input  wire logic             rgb_ready
);

   logic                 valid_ff, valid_in;
   logic [PIX_W-1:0]     raw_ff;
   logic [CW-1:0]        col_ff;
   pix_flags_type        flags_ff;
   logic                 fwd_ff;
   logic [PIX_W-1:0]     fwd_upper_ff, fwd_middle_ff;
   logic [PIX_W-1:0]     win_ff [6];

   logic                 commit;
   logic [PIX_W-1:0]     upper_q, middle_q;
   logic [PIX_W-1:0]     tr, mr;
   logic [PIX_W+1:0]     cross_sum, corner_sum;
   logic [PIX_W:0]       horiz_sum, vert_sum;

   assign commit   = valid_ff && rgb_ready;
   assign in_ready = !valid_ff || rgb_ready;
   assign valid_in = in_accept ? 1'b1 : (commit ? 1'b0 : valid_ff);

   bbg_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (col_ff),
      .wr_data (mr),
      .rd_en   (in_accept),
      .rd_addr (in_col),
      .rd_data (upper_q)
   );

   bbg_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (col_ff),
      .wr_data (raw_ff),
      .rd_en   (in_accept),
      .rd_addr (in_col),
      .rd_data (middle_q)
   );

   // a read that meets the write of the item ahead sees stale data
   assign tr = fwd_ff ? fwd_upper_ff  : upper_q;
   assign mr = fwd_ff ? fwd_middle_ff : middle_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (in_accept) begin
            fwd_ff <= commit && (col_ff == in_col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         raw_ff        <= in_raw;
         col_ff        <= in_col;
         flags_ff      <= in_flags;
         fwd_upper_ff  <= mr;
         fwd_middle_ff <= raw_ff;
      end
   end

   // window: 0..2 left column, 3..5 centre column, top to bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (commit) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= tr;
         win_ff[4] <= mr;
         win_ff[5] <= raw_ff;
      end
   end

   always_comb begin
      cross_sum  = (PIX_W+2)'(win_ff[1]) + (PIX_W+2)'(mr)
                 + (PIX_W+2)'(win_ff[3]) + (PIX_W+2)'(win_ff[5]);
      corner_sum = (PIX_W+2)'(win_ff[0]) + (PIX_W+2)'(tr)
                 + (PIX_W+2)'(win_ff[2]) + (PIX_W+2)'(raw_ff);
      horiz_sum  = (PIX_W+1)'(win_ff[1]) + (PIX_W+1)'(mr);
      vert_sum   = (PIX_W+1)'(win_ff[3]) + (PIX_W+1)'(win_ff[5]);
      rgb_data.last = flags_ff.last;
      if (flags_ff.y_odd) begin
         if (flags_ff.x_odd) begin
            rgb_data.r = win_ff[4];
            rgb_data.g = cross_sum[PIX_W+1:2];
            rgb_data.b = corner_sum[PIX_W+1:2];
         end else begin
            rgb_data.r = horiz_sum[PIX_W:1];
            rgb_data.g = win_ff[4];
            rgb_data.b = vert_sum[PIX_W:1];
         end
      end else begin
         if (flags_ff.x_odd) begin
            rgb_data.r = vert_sum[PIX_W:1];
            rgb_data.g = win_ff[4];
            rgb_data.b = horiz_sum[PIX_W:1];
         end else begin
            rgb_data.r = corner_sum[PIX_W+1:2];
            rgb_data.g = cross_sum[PIX_W+1:2];
            rgb_data.b = win_ff[4];
         end
      end
   end

   assign rgb_valid = commit && flags_ff.interior;

endmodule

`default_nettype wire

// ----- src/bbg_luma.sv -----
// input stage register, weighted luma sum and output register
`default_nettype none

module bbg_luma
   import bbg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rgb_valid,
   input  wire rgb_type          rgb_data,
   output logic                  rgb_ready,
   output logic                  out_valid,
   output logic [PIX_W-1:0]      out_gray,
   output logic                  out_last,
   input  wire logic             out_ready
);

   logic             stage_valid_ff;
   rgb_type          stage_ff;
   logic             out_valid_ff;
   logic [PIX_W-1:0] gray_ff;
   logic             last_ff;

   logic             out_free, advance;
   logic [15:0]      luma_sum;

   assign out_free  = !out_valid_ff || out_ready;
   assign advance   = stage_valid_ff && out_free;
   assign rgb_ready = !stage_valid_ff || out_free;

   // weights sum to 256, so the total never leaves 16 bits
   assign luma_sum = 16'(W_RED) * 16'(stage_ff.r) + 16'(W_GREEN) * 16'(stage_ff.g)
                   + 16'(W_BLUE) * 16'(stage_ff.b);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (rgb_valid) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rgb_valid) begin
         stage_ff <= rgb_data;
      end
      if (advance) begin
         gray_ff <= luma_sum[15:8];
         last_ff <= stage_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_gray  = gray_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ----- src/bayer_bilinear_to_gray_top.sv -----
// top level: registers, raster coordinates and pipeline hook-up
//
// Raw Bayer samples enter in raster order, one per clock, and each interior
// pixel leaves as one 8-bit gray value (77r+150g+29b)>>8, with tlast on the
// last interior pixel of the frame; the one-pixel border gives no output.
// The block takes one sample every cycle while the output side keeps up: the
// two line stores are read when a sample is taken and written back when it
// leaves the window register, the entry being forwarded when the next sample
// hits the same column. A pixel's result passes the luma stage and output
// registers once the sample to its lower right is taken. Line stores need no
// clearing pass; tuser set on a sample restarts coordinates at row 0, column 0.
// Registers line_width (index 0) and frame_height (index 1) are saturated to
// 3..MAX_WIDTH and 3..1024 and should be written only while the block is idle.
`default_nettype none

module bayer_bilinear_to_gray_top
   import bbg_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // raw_pixel
   input  wire logic                 req_tuser,   // frame_start
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [7:0]           rsp_tdata,   // gray
   output logic                      rsp_tlast,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;

   logic [CSR_W-1:0] line_width_ff, frame_height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             accept;
   logic [CW-1:0]    col_cur;
   logic [ROW_W-1:0] row_cur;
   logic [CMPW-1:0]  col_next;
   logic [ROW_W:0]   row_next;
   logic             row_end;
   pix_flags_type    flags;

   logic             rgb_valid, rgb_ready;
   rgb_type          rgb_data;

   // register writes with saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_LINE_WIDTH: begin
               if (csr_wdata < CSR_W'(DIM_MIN)) begin
                  line_width_ff <= CSR_W'(DIM_MIN);
               end else if (CMPW'(csr_wdata) > CMPW'(MAX_WIDTH)) begin
                  line_width_ff <= CSR_W'(MAX_WIDTH);
               end else begin
                  line_width_ff <= csr_wdata;
               end
            end
            REG_FRAME_HEIGHT: begin
               if (csr_wdata < CSR_W'(DIM_MIN)) begin
                  frame_height_ff <= CSR_W'(DIM_MIN);
               end else if (csr_wdata > CSR_W'(HEIGHT_MAX)) begin
                  frame_height_ff <= CSR_W'(HEIGHT_MAX);
               end else begin
                  frame_height_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign col_cur  = req_tuser ? '0 : col_ff;
   assign row_cur  = req_tuser ? '0 : row_ff;
   assign col_next = CMPW'(col_cur) + CMPW'(1);
   assign row_next = (ROW_W+1)'(row_cur) + (ROW_W+1)'(1);
   assign row_end  = col_next >= CMPW'(line_width_ff);

   always_comb begin
      flags.interior = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
      flags.x_odd    = !col_cur[0];
      flags.y_odd    = !row_cur[0];
      flags.last     = (CSR_W'(row_next) == frame_height_ff)
                    && (col_next == CMPW'(line_width_ff));
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = (CSR_W'(row_next) >= frame_height_ff) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   bbg_window #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_raw    (req_tdata),
      .in_col    (col_cur),
      .in_flags  (flags),
      .in_ready  (req_tready),
      .rgb_valid (rgb_valid),
      .rgb_data  (rgb_data),
      .rgb_ready (rgb_ready)
   );

   bbg_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .rgb_valid (rgb_valid),
      .rgb_data  (rgb_data),
      .rgb_ready (rgb_ready),
      .out_valid (rsp_tvalid),
      .out_gray  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule

`default_nettype wire

// ----- verif/bayer_bilinear_to_gray_top_test.sv -----
// self-checking testbench for the bayer to gray block: streamed raw frames against a local model
module bayer_bilinear_to_gray_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bbg_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH_DEF;

   typedef struct packed {
      logic [PIX_W-1:0] raw;
      logic             frame_start;
   } raw_sample_type;

   typedef struct packed {
      logic [PIX_W-1:0] gray;
      logic             frame_last;
   } gray_result_type;

   typedef enum {
      IDLE_RX_HEAVY,
      IDLE_TX_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // raw_pixel
   logic                 req_tuser  = 1'b0; // frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // gray
   logic                 rsp_tlast;
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   raw_sample_type  raw_pending [$];
   gray_result_type gray_expected [$];
   raw_sample_type  offered;
   gray_result_type oldest_gray;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned fault_count = 0;
   logic        hold_off    = 1'b0;
   bit          squeeze_go  = 1'b0;

   // local copy of the block state
   int unsigned line_cfg   = 320;
   int unsigned height_cfg = 200;
   int unsigned col_pos    = 0;
   int unsigned row_pos    = 0;
   logic [7:0]  upper_line  [STORE_DEPTH];
   logic [7:0]  middle_line [STORE_DEPTH];
   logic [7:0]  left_tap   [3] = '{default: 8'd0};   // top, middle, bottom
   logic [7:0]  centre_tap [3] = '{default: 8'd0};

   bayer_bilinear_to_gray_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned saturate(input int unsigned value, input int unsigned hi);
      if (value < DIM_MIN) return DIM_MIN;
      if (value > hi) return hi;
      return value;
   endfunction

   // bilinear rebuild of one pixel and its luma, then window shift and store update
   function automatic void predict_gray(input raw_sample_type s);
      int unsigned col, row, x, y, r, g, b, cross_avg, corners;
      int unsigned tl, tc, tr, ml, mc, mr, bl, bc, br;
      gray_result_type res;
      if (s.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      tl = left_tap[0];   ml = left_tap[1];   bl = left_tap[2];
      tc = centre_tap[0]; mc = centre_tap[1]; bc = centre_tap[2];
      tr = upper_line[col];
      mr = middle_line[col];
      br = s.raw;
      if (row >= 2 && col >= 2) begin
         x = col - 1;
         y = row - 1;
         cross_avg = (ml + mr + tc + bc) >> 2;
         corners   = (tl + tr + bl + br) >> 2;
         if (y[0]) begin
            if (x[0]) begin
               r = mc; g = cross_avg; b = corners;
            end else begin
               r = (ml + mr) >> 1; g = mc; b = (tc + bc) >> 1;
            end
         end else begin
            if (x[0]) begin
               r = (tc + bc) >> 1; g = mc; b = (ml + mr) >> 1;
            end else begin
               r = corners; g = cross_avg; b = mc;
            end
         end
         res.gray       = 8'((W_RED * r + W_GREEN * g + W_BLUE * b) >> 8);
         res.frame_last = (row == height_cfg - 1) && (col == line_cfg - 1);
         gray_expected.push_back(res);
      end
      left_tap[0]   = tc[7:0]; left_tap[1]   = mc[7:0]; left_tap[2]   = bc[7:0];
      centre_tap[0] = tr[7:0]; centre_tap[1] = mr[7:0]; centre_tap[2] = br[7:0];
      upper_line[col]  = mr[7:0];
      middle_line[col] = s.raw;
      if (col + 1 >= line_cfg) begin
         col_pos = 0;
         row_pos = (row + 1 >= height_cfg) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   // driver: one transfer offered at a time, predicted when taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_gray(offered);
         if (!req_tvalid || req_tready) begin
            if (raw_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               offered = raw_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.raw;
               req_tuser  <= offered.frame_start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (gray_expected.size() == 0) begin
               $error("gray: no result expected, got %0d", rsp_tdata);
               fault_count++;
            end else begin
               oldest_gray = gray_expected.pop_front();
               if (rsp_tdata !== oldest_gray.gray) begin
                  $error("gray: expected %0d, got %0d", oldest_gray.gray, rsp_tdata);
                  fault_count++;
               end
               if (rsp_tlast !== oldest_gray.frame_last) begin
                  $error("frame_last: expected %0d, got %0d", oldest_gray.frame_last,
                         rsp_tlast);
                  fault_count++;
               end
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long receiver hold-off so the pipeline backs up into the input
   initial begin
      wait (squeeze_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("bayer_bilinear_to_gray_top_test NOT OK");
      $finish;
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (raw_pending.size() != 0 || req_tvalid || gray_expected.size() != 0);
      // border samples give no result but may still be in flight
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_LINE_WIDTH)
         line_cfg = saturate(value, MAX_WIDTH_DEF);
      else
         height_cfg = saturate(value, HEIGHT_MAX);
   endtask

   task automatic start_phase(input logic [CSR_W-1:0] width_val,
                              input logic [CSR_W-1:0] height_val,
                              input idle_mode_type mode);
      wait_idle();
      write_reg(REG_LINE_WIDTH, width_val);
      write_reg(REG_FRAME_HEIGHT, height_val);
      @(negedge clock);
      case (mode)
         IDLE_RX_HEAVY: begin
            tx_idle_pct = 10;
            rx_idle_pct = 88;
         end
         IDLE_TX_HEAVY: begin
            tx_idle_pct = 88;
            rx_idle_pct = 10;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endtask

   function automatic logic [7:0] random_raw();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // raster frames with random content; the first sample always restarts the frame
   // so stores are refilled after a width change
   task automatic queue_frames(input int unsigned count, input bit allow_restart);
      int unsigned pos, frame_len;
      raw_sample_type s;
      frame_len = line_cfg * height_cfg;
      pos = 0;
      for (int unsigned i = 0; i < count; i++) begin
         s.raw = random_raw();
         if (i == 0)
            s.frame_start = 1'b1;
         else if (pos == 0)
            s.frame_start = ($urandom_range(3) != 0);
         else
            s.frame_start = allow_restart && ($urandom_range(59) == 0);
         if (s.frame_start)
            pos = 0;
         pos = (pos + 1) % frame_len;
         raw_pending.push_back(s);
      end
   endtask

   initial begin
      raw_sample_type s;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // 4x4 checkerboard of extremes covers all four bayer phases, then a wrap
      start_phase(11'd4, 11'd4, IDLE_RX_HEAVY);
      for (int i = 0; i < 21; i++) begin
         s.raw         = (i < 16 && ((i ^ (i >> 2)) & 1) == 0) ? 8'd0 : 8'd255;
         s.frame_start = (i == 0);
         raw_pending.push_back(s);
      end

      start_phase(11'd5, 11'd2, IDLE_RX_HEAVY);
      queue_frames(100, 1'b1);
      // wide row, shortest frame
      start_phase(11'd120, 11'd0, IDLE_RX_HEAVY);
      queue_frames(3 * 120, 1'b0);

      start_phase(11'd7, 11'd9, IDLE_TX_HEAVY);
      queue_frames(120, 1'b1);
      // narrowest row, tallest frame
      start_phase(11'd1, 11'd2047, IDLE_TX_HEAVY);
      queue_frames(3 * 40, 1'b0);

      start_phase(11'd16, 11'd5, IDLE_NONE);
      queue_frames(100, 1'b1);
      squeeze_go = 1'b1;
      start_phase(11'($urandom_range(3, 12)), 11'($urandom_range(3, 12)), IDLE_NONE);
      queue_frames(100, 1'b1);

      wait_idle();
      if (fault_count == 0 && gray_expected.size() == 0)
         $display("bayer_bilinear_to_gray_top_test OK");
      else
         $display("bayer_bilinear_to_gray_top_test NOT OK");
      $finish;
   end

endmodule
